// ===== hw/rtl/gfc_pkg.sv =====
// ----------------------------------------------------------------------------
// gfc_pkg: shared types and constants
// Field widths, register indexes and the face record for the face
// connectivity generator.
// ----------------------------------------------------------------------------
package gfc_pkg;

  // fixed field widths
  localparam int FACE_W = 22;
  localparam int CELL_W = 20;
  localparam int SIZE_REG_W = 11;
  localparam int CFG_IDX_W = 2;

  // default largest grid extent per axis
  localparam int DEF_MAX_CELLS_PER_AXIS = 1024;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 2'd1;

  // one emitted face
  typedef struct packed {
    logic [FACE_W-1:0] face_index;
    logic [CELL_W-1:0] owner_cell;
    logic [CELL_W-1:0] neighbor_cell;
    logic              neighbor_valid;
    logic              horizontal;
    logic              normal_negative;
    logic              half_distance;
    logic              last_face;
  } face_t;

endpackage

// ===== hw/rtl/grid_face_connectivity_generator.sv =====
// ----------------------------------------------------------------------------
// grid_face_connectivity_generator: structured grid face walker
// Emits the faces of a cells_x by cells_y grid with owner and neighbor cells.
// ----------------------------------------------------------------------------
// Each accepted input word yields exactly one face word, one per clock cycle
// sustained: the face is decoded from the walk position in a single stage and
// lands in the output register, and a new word is taken whenever that register
// is empty or being drained. Vertical faces come first, row by row (cells_x+1
// per row), then horizontal faces (cells_x per row, cells_y+1 rows); the final
// face carries tlast and the walk wraps to face zero. A restart bit set in the
// input word emits face zero. Register writes (cells_x, cells_y; zero acts as
// one, values above MAX_CELLS_PER_AXIS are clamped) also return the walk to
// face zero and must be made while no face is outstanding.
module grid_face_connectivity_generator #(
  parameter int MAX_CELLS_PER_AXIS = gfc_pkg::DEF_MAX_CELLS_PER_AXIS
) (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [0] restart
  // output stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [21:0] face_index, [41:22] owner_cell, [61:42] neighbor_cell,
  // [62] neighbor_valid, [63] normal_negative, [64] half_distance
  output logic [71:0]                    m_tdata,
  output logic                           m_tuser,   // [0] horizontal
  output logic                           m_tlast,   // last_face
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gfc_pkg::SIZE_REG_W-1:0] cfg_data
);

  localparam int MAX_W = $clog2(MAX_CELLS_PER_AXIS + 1);
  localparam int SZ_W  = (MAX_W > gfc_pkg::SIZE_REG_W) ? MAX_W : gfc_pkg::SIZE_REG_W;
  localparam logic [SZ_W-1:0] MAX_SZ = SZ_W'(MAX_CELLS_PER_AXIS);

  logic [gfc_pkg::SIZE_REG_W-1:0] cells_x;
  logic [gfc_pkg::SIZE_REG_W-1:0] cells_y;
  logic [SZ_W-1:0]                nx;
  logic [SZ_W-1:0]                ny;
  logic                           cfg_hit;
  logic                           s_accept;
  gfc_pkg::face_t                 cur_face;
  gfc_pkg::face_t                 out_face;
  logic                           out_valid;

  // register port
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid &&
                     (cfg_index == gfc_pkg::REG_CELLS_X || cfg_index == gfc_pkg::REG_CELLS_Y);

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_x <= gfc_pkg::SIZE_REG_W'(1);
      cells_y <= gfc_pkg::SIZE_REG_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gfc_pkg::REG_CELLS_X: cells_x <= cfg_data;
        gfc_pkg::REG_CELLS_Y: cells_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sizes
  always_comb begin
    nx = SZ_W'(cells_x);
    ny = SZ_W'(cells_y);
    if (cells_x == '0) nx = SZ_W'(1);
    else if (SZ_W'(cells_x) > MAX_SZ) nx = MAX_SZ;
    if (cells_y == '0) ny = SZ_W'(1);
    else if (SZ_W'(cells_y) > MAX_SZ) ny = MAX_SZ;
  end

  // handshake
  assign s_tready = !out_valid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  gfc_seq #(
    .SZ_W               (SZ_W)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .clear   (cfg_hit),
    .advance (s_accept),
    .restart (s_tdata[0]),
    .nx      (nx),
    .ny      (ny),
    .face    (cur_face)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      out_face <= cur_face;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_face.half_distance, out_face.normal_negative,
                     out_face.neighbor_valid, out_face.neighbor_cell,
                     out_face.owner_cell, out_face.face_index};
  assign m_tuser  = out_face.horizontal;
  assign m_tlast  = out_face.last_face;

  // interior faces carry a neighbor and full spacing, boundary faces the reverse
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_face.neighbor_valid != out_face.half_distance))
    else $error("face word mixes interior and boundary flags");

  // the last face is a top boundary horizontal face
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_face.last_face |-> out_face.horizontal && !out_face.neighbor_valid
                                        && !out_face.normal_negative)
    else $error("last face is not a top boundary face");

  // a restart word yields face zero
  assert property (@(posedge clk) disable iff (rst)
    s_accept && s_tdata[0] |=> out_valid && (out_face.face_index == '0))
    else $error("restart did not emit face zero");

endmodule

// ===== hw/rtl/gfc_seq.sv =====
// ----------------------------------------------------------------------------
// gfc_seq: face sequencer
// Holds the face walk position and decodes the current face from it; the
// position advances on each accepted word.
// ----------------------------------------------------------------------------
module gfc_seq #(
  parameter int SZ_W = 11
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                advance,
  input  logic                restart,
  input  logic [SZ_W-1:0]     nx,
  input  logic [SZ_W-1:0]     ny,
  output gfc_pkg::face_t      face
);

  localparam int RB_W = 2 * SZ_W;

  // walk position
  logic [SZ_W-1:0]           column;
  logic [SZ_W-1:0]           row;
  logic                      phase;
  logic [gfc_pkg::FACE_W-1:0] face_count;
  logic [RB_W-1:0]           row_base;

  logic [SZ_W-1:0]           column_next;
  logic [SZ_W-1:0]           row_next;
  logic                      phase_next;
  logic [gfc_pkg::FACE_W-1:0] face_count_next;
  logic [RB_W-1:0]           row_base_next;

  // position seen by this word, after an optional restart
  logic [SZ_W-1:0]           col_w;
  logic [SZ_W-1:0]           row_w;
  logic                      ph_w;
  logic [gfc_pkg::FACE_W-1:0] fc_w;
  logic [RB_W-1:0]           rb_w;

  logic [SZ_W:0]             col_inc;
  logic [SZ_W:0]             row_inc;
  logic [RB_W-1:0]           nx_w;
  logic [RB_W-1:0]           owner_w;
  logic [RB_W-1:0]           nb_w;
  logic                      nbv;
  logic                      neg;
  logic                      half;
  logic                      last;

  assign col_w = restart ? '0 : column;
  assign row_w = restart ? '0 : row;
  assign ph_w  = restart ? 1'b0 : phase;
  assign fc_w  = restart ? '0 : face_count;
  assign rb_w  = restart ? '0 : row_base;

  assign col_inc = {1'b0, col_w} + 1'b1;
  assign row_inc = {1'b0, row_w} + 1'b1;
  assign nx_w    = RB_W'(nx);

  // face decode
  always_comb begin
    owner_w = '0;
    nb_w    = '0;
    nbv     = 1'b0;
    neg     = 1'b0;
    half    = 1'b0;
    last    = 1'b0;
    if (!ph_w) begin
      if (col_w == '0) begin
        owner_w = rb_w;
        neg     = 1'b1;
        half    = 1'b1;
      end else if (col_w >= nx) begin
        owner_w = rb_w + nx_w - 1'b1;
        half    = 1'b1;
      end else begin
        owner_w = rb_w + RB_W'(col_w) - 1'b1;
        nb_w    = rb_w + RB_W'(col_w);
        nbv     = 1'b1;
      end
    end else begin
      if (row_w == '0) begin
        owner_w = RB_W'(col_w);
        neg     = 1'b1;
        half    = 1'b1;
      end else if (row_w >= ny) begin
        owner_w = rb_w - nx_w + RB_W'(col_w);
        half    = 1'b1;
        last    = (col_inc >= {1'b0, nx});
      end else begin
        owner_w = rb_w - nx_w + RB_W'(col_w);
        nb_w    = rb_w + RB_W'(col_w);
        nbv     = 1'b1;
      end
    end
  end

  assign face.face_index      = fc_w;
  assign face.owner_cell      = owner_w[gfc_pkg::CELL_W-1:0];
  assign face.neighbor_cell   = nb_w[gfc_pkg::CELL_W-1:0];
  assign face.neighbor_valid  = nbv;
  assign face.horizontal      = ph_w;
  assign face.normal_negative = neg;
  assign face.half_distance   = half;
  assign face.last_face       = last;

  // next position
  always_comb begin
    column_next     = col_w;
    row_next        = row_w;
    phase_next      = ph_w;
    face_count_next = fc_w;
    row_base_next   = rb_w;
    if (last) begin
      column_next     = '0;
      row_next        = '0;
      phase_next      = 1'b0;
      face_count_next = '0;
      row_base_next   = '0;
    end else begin
      face_count_next = fc_w + 1'b1;
      column_next     = col_inc[SZ_W-1:0];
      if (!ph_w) begin
        if (col_inc > {1'b0, nx}) begin
          column_next   = '0;
          row_next      = row_inc[SZ_W-1:0];
          row_base_next = rb_w + nx_w;
          if (row_inc >= {1'b0, ny}) begin
            row_next      = '0;
            row_base_next = '0;
            phase_next    = 1'b1;
          end
        end
      end else begin
        if (col_inc >= {1'b0, nx}) begin
          column_next   = '0;
          row_next      = row_inc[SZ_W-1:0];
          row_base_next = rb_w + nx_w;
        end
      end
    end
  end

  // position registers
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      column     <= '0;
      row        <= '0;
      phase      <= 1'b0;
      face_count <= '0;
      row_base   <= '0;
    end else if (advance) begin
      column     <= column_next;
      row        <= row_next;
      phase      <= phase_next;
      face_count <= face_count_next;
      row_base   <= row_base_next;
    end
  end

  // the walk never runs past the last row of horizontal faces
  assert property (@(posedge clk) disable iff (rst)
    phase |-> (row <= ny))
    else $error("gfc_seq: row beyond grid in horizontal phase");

  // vertical faces never see the row counter reach the row count
  assert property (@(posedge clk) disable iff (rst)
    !phase |-> (row < ny) && (column <= nx))
    else $error("gfc_seq: position outside grid in vertical phase");

  // a wrap after the last face returns to face zero
  assert property (@(posedge clk) disable iff (rst)
    advance && !clear && last |=> (face_count == '0) && !phase)
    else $error("gfc_seq: no wrap after last face");

endmodule

// ===== tb/tb_grid_face_connectivity_generator.sv =====
// ----------------------------------------------------------------------------
// tb_grid_face_connectivity_generator: face walker self-checking bench
// Streams restart/advance words into the generator, predicts every face from
// a local model of the walk, and checks each face word field by field.
// Grid sizes change between phases, including zero, clamped and ignored
// register writes, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_grid_face_connectivity_generator;

  localparam int CLK_HALF = 4;
  localparam int STALL_PCT = 8;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_WORDS = 1650;
  localparam int PRINT_CAP = 40;

  // register indexes the block does not decode
  localparam logic [gfc_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [gfc_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [7:0]                     s_tdata;   // [0] restart
  logic                           m_tvalid;
  logic                           m_tready;
  // [21:0] face_index, [41:22] owner_cell, [61:42] neighbor_cell,
  // [62] neighbor_valid, [63] normal_negative, [64] half_distance
  logic [71:0]                    m_tdata;
  logic                           m_tuser;   // [0] horizontal
  logic                           m_tlast;   // last_face
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [gfc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [gfc_pkg::SIZE_REG_W-1:0] cfg_data;

  grid_face_connectivity_generator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // walk model state
  logic [gfc_pkg::SIZE_REG_W-1:0] size_x;
  logic [gfc_pkg::SIZE_REG_W-1:0] size_y;
  logic [10:0]                    walk_col;
  logic [10:0]                    walk_row;
  logic                           walk_horiz;
  logic [gfc_pkg::FACE_W-1:0]     walk_count;
  logic [20:0]                    walk_base;

  gfc_pkg::face_t expected_faces[$];
  int    mismatches = 0;
  bit    calm = 0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // grid extent as the walker uses it
  function automatic int unsigned eff_size(input logic [gfc_pkg::SIZE_REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > gfc_pkg::DEF_MAX_CELLS_PER_AXIS) return gfc_pkg::DEF_MAX_CELLS_PER_AXIS;
    return v;
  endfunction

  function automatic void clear_walk();
    walk_col = '0;
    walk_row = '0;
    walk_horiz = 1'b0;
    walk_count = '0;
    walk_base = '0;
  endfunction

  function automatic void apply_reg(input logic [gfc_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [gfc_pkg::SIZE_REG_W-1:0] val);
    case (idx)
      gfc_pkg::REG_CELLS_X: begin
        size_x = val;
        clear_walk();
      end
      gfc_pkg::REG_CELLS_Y: begin
        size_y = val;
        clear_walk();
      end
      default: ;
    endcase
  endfunction

  // face produced by one input word, then step the walk
  function automatic gfc_pkg::face_t next_face(input logic restart);
    int unsigned nx;
    int unsigned ny;
    int unsigned owner;
    int unsigned nbr;
    gfc_pkg::face_t f;
    nx = eff_size(size_x);
    ny = eff_size(size_y);
    owner = 0;
    nbr = 0;
    f = '0;
    if (restart) clear_walk();
    f.face_index = walk_count;
    f.horizontal = walk_horiz;
    if (!walk_horiz) begin
      if (walk_col == 0) begin
        owner = walk_base;
        f.normal_negative = 1'b1;
        f.half_distance = 1'b1;
      end else if (walk_col >= nx) begin
        owner = walk_base + nx - 1;
        f.half_distance = 1'b1;
      end else begin
        owner = walk_base + walk_col - 1;
        nbr = walk_base + walk_col;
        f.neighbor_valid = 1'b1;
      end
    end else begin
      if (walk_row == 0) begin
        owner = walk_col;
        f.normal_negative = 1'b1;
        f.half_distance = 1'b1;
      end else if (walk_row >= ny) begin
        owner = walk_base - nx + walk_col;
        f.half_distance = 1'b1;
        if (walk_col + 1 >= nx) f.last_face = 1'b1;
      end else begin
        owner = walk_base - nx + walk_col;
        nbr = walk_base + walk_col;
        f.neighbor_valid = 1'b1;
      end
    end
    f.owner_cell = gfc_pkg::CELL_W'(owner);
    f.neighbor_cell = gfc_pkg::CELL_W'(nbr);

    if (f.last_face) begin
      clear_walk();
    end else begin
      walk_count = walk_count + 1'b1;
      walk_col = walk_col + 1'b1;
      if (!walk_horiz) begin
        if (walk_col > nx) begin
          walk_col = '0;
          walk_row = walk_row + 1'b1;
          walk_base = 21'(walk_base + nx);
          if (walk_row >= ny) begin
            walk_row = '0;
            walk_base = '0;
            walk_horiz = 1'b1;
          end
        end
      end else if (walk_col >= nx) begin
        walk_col = '0;
        walk_row = walk_row + 1'b1;
        walk_base = 21'(walk_base + nx);
      end
    end
    return f;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < PRINT_CAP)
      $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // send one word, with an occasional gap ahead of it
  task automatic send_word(input logic restart);
    if (!calm && $urandom_range(0, 99) < STALL_PCT) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {7'b0, restart};
    do @(posedge clk); while (!s_tready);
    expected_faces.push_back(next_face(restart));
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [gfc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gfc_pkg::SIZE_REG_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
    @(negedge clk);
  endtask

  // stop the input stream and let every face drain
  task automatic settle();
    s_tvalid = 1'b0;
    while (expected_faces.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [gfc_pkg::SIZE_REG_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return gfc_pkg::SIZE_REG_W'(gfc_pkg::DEF_MAX_CELLS_PER_AXIS);
    if (r < 11) return '1;
    if (r < 14) return gfc_pkg::SIZE_REG_W'($urandom);
    return gfc_pkg::SIZE_REG_W'($urandom_range(1, 9));
  endfunction

  // reset sizes: 1 by 1 grid walks four faces and wraps
  task automatic test_reset_sizes();
    repeat (5) send_word(1'b0);
    send_word(1'b1);
    send_word(1'b0);
  endtask

  // zero sizes act as one; spare indexes leave the walk alone
  task automatic test_zero_and_spare_regs();
    settle();
    write_reg(gfc_pkg::REG_CELLS_X, '0);
    write_reg(gfc_pkg::REG_CELLS_Y, '0);
    repeat (2) send_word(1'b0);
    settle();
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, 11'h2aa);
    repeat (3) send_word(1'b0);
  endtask

  // restart in the middle of a walk
  task automatic test_restart_midwalk();
    settle();
    write_reg(gfc_pkg::REG_CELLS_X, 11'd3);
    write_reg(gfc_pkg::REG_CELLS_Y, 11'd2);
    repeat (3) send_word(1'b0);
    send_word(1'b1);
    repeat (4) send_word(1'b0);
  endtask

  // largest and clamped sizes
  task automatic test_extreme_sizes();
    settle();
    write_reg(gfc_pkg::REG_CELLS_X, '1);
    write_reg(gfc_pkg::REG_CELLS_Y, gfc_pkg::SIZE_REG_W'(gfc_pkg::DEF_MAX_CELLS_PER_AXIS));
    send_word(1'b1);
    repeat (3) send_word(1'b0);
    send_word(1'b1);
  endtask

  // random grids, mostly whole walks with a little restart noise
  task automatic test_random_walks();
    int sent;
    int phase;
    int n;
    int unsigned nx;
    int unsigned ny;
    int unsigned faces;
    logic [gfc_pkg::SIZE_REG_W-1:0] vx;
    logic [gfc_pkg::SIZE_REG_W-1:0] vy;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      settle();
      calm = (phase >= 6 && phase < 9);
      vx = pick_size();
      vy = pick_size();
      if ($urandom_range(0, 1)) begin
        write_reg(gfc_pkg::REG_CELLS_X, vx);
        write_reg(gfc_pkg::REG_CELLS_Y, vy);
      end else begin
        write_reg(gfc_pkg::REG_CELLS_Y, vy);
        write_reg(gfc_pkg::REG_CELLS_X, vx);
      end
      if ($urandom_range(0, 9) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                  gfc_pkg::SIZE_REG_W'($urandom));
      nx = eff_size(vx);
      ny = eff_size(vy);
      faces = (nx + 1) * ny + nx * (ny + 1);
      if (faces > 300) n = $urandom_range(10, 40);
      else n = faces + $urandom_range(1, faces);
      if (n > RANDOM_WORDS - sent) n = RANDOM_WORDS - sent;
      repeat (n) send_word($urandom_range(0, 99) < 3);
      sent += n;
      phase++;
    end
    calm = 0;
  endtask

  // output stall pattern
  always @(negedge clk) begin
    m_tready = calm || ($urandom_range(0, 99) >= STALL_PCT);
  end

  // compare each face word with the oldest prediction
  always @(posedge clk) begin
    gfc_pkg::face_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_faces.size() == 0) begin
        report_mismatch("unexpected face, index", m_tdata[21:0], -1);
      end else begin
        want = expected_faces.pop_front();
        if (m_tdata[21:0] != want.face_index)
          report_mismatch("face_index", m_tdata[21:0], want.face_index);
        if (m_tdata[41:22] != want.owner_cell)
          report_mismatch("owner_cell", m_tdata[41:22], want.owner_cell);
        if (m_tdata[61:42] != want.neighbor_cell)
          report_mismatch("neighbor_cell", m_tdata[61:42], want.neighbor_cell);
        if (m_tdata[62] != want.neighbor_valid)
          report_mismatch("neighbor_valid", m_tdata[62], want.neighbor_valid);
        if (m_tdata[63] != want.normal_negative)
          report_mismatch("normal_negative", m_tdata[63], want.normal_negative);
        if (m_tdata[64] != want.half_distance)
          report_mismatch("half_distance", m_tdata[64], want.half_distance);
        if (m_tuser != want.horizontal)
          report_mismatch("horizontal", m_tuser, want.horizontal);
        if (m_tlast != want.last_face)
          report_mismatch("last_face", m_tlast, want.last_face);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // main sequence
  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = gfc_pkg::REG_CELLS_X;
    cfg_data = '0;
    size_x = 11'd1;
    size_y = 11'd1;
    clear_walk();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_sizes();
    test_zero_and_spare_regs();
    test_restart_midwalk();
    test_extreme_sizes();
    test_random_walks();

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
